FILE: rtl/core/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

  // working width for signed intermediates
  localparam int unsigned WW = 64;

  // shared multiplier operand and product widths
  localparam int unsigned MA_W = 50;
  localparam int unsigned MB_W = 18;
  localparam int unsigned MP_W = MA_W + MB_W;

  // iterative divider
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // field widths
  localparam int unsigned UT_W   = 16;
  localparam int unsigned RAW_W  = 24;
  localparam int unsigned UP_W   = 19;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned PRES_W = 18;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned B5_W   = 29;
  localparam int unsigned T_W    = 25;
  localparam int unsigned B4_W   = 17;
  localparam int unsigned N_W    = 22;
  localparam int unsigned Q0_W   = 19;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;

  // compensation constants
  localparam logic signed [B5_W-1:0] TEMP_OFFS  = 29'sd4000;
  localparam logic        [B4_W-1:0] B7_SCALE   = 17'd50000;
  localparam logic signed [WW-1:0]   B4_BIAS    = 64'sd32768;
  localparam logic signed [MB_W-1:0] C_P1       = 18'sd3038;
  localparam logic signed [MB_W-1:0] C_P2       = -18'sd7357;
  localparam logic signed [WW-1:0]   C_P3       = 64'sd3791;
  localparam logic signed [WW-1:0]   PMAX       = 64'sd262143;
  localparam logic signed [T_W-1:0]  TEMP_MAX   = 25'sd32767;
  localparam logic signed [T_W-1:0]  TEMP_MIN   = -25'sd32768;

  // divide by ten: q0 = (n * DIV10_M) >> DIV10_SH is q or q + 1
  localparam logic signed [MB_W-1:0] DIV10_M  = 18'sd52429;
  localparam int unsigned            DIV10_SH = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AC1_AC4 = 4'd0,
    CFG_AC5_B2  = 4'd1,
    CFG_MC_MD   = 4'd2,
    CFG_OSS     = 4'd3
  } cfg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_TZERO = 2'd1,
    STAT_PZERO = 2'd2,
    STAT_SAT   = 2'd3
  } stat_e;

  typedef enum logic [4:0] {
    ST_T_MUL, ST_T_X1, ST_T_CHK, ST_T_X2, ST_T_B5, ST_T_B6,
    ST_SQ_LO, ST_SQ_HI, ST_SQ, ST_AC2, ST_B2, ST_X3A, ST_B3, ST_X3B,
    ST_B4_MUL, ST_B4, ST_P_CHK, ST_B7, ST_P_DIV, ST_P_Q,
    ST_PS_LO, ST_PS_HI, ST_PS, ST_C1, ST_C2, ST_C3, ST_PCOR, ST_SAT,
    ST_F_MUL, ST_F_Q, ST_FILT
  } step_e;

  typedef struct packed {
    step_e step;
    logic  exec;
    logic  div_start;
    logic  load_in;
    logic  load_out;
    stat_e code;
  } bpc_cmd_t;

  typedef struct packed {
    logic tzero;
    logic pzero;
    logic div_done;
  } bpc_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/bpc_if.sv
`default_nettype none
interface bpc_in_if import bpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [UT_W-1:0]  raw_temperature;
  logic [RAW_W-1:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if import bpc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic [PRES_W-1:0]        pressure_pa;
  logic [PRES_W-1:0]        filtered_pressure_pa;
  logic [STAT_W-1:0]        status;
  modport source (output valid, temperature_tenths, pressure_pa, filtered_pressure_pa,
                  status, input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, filtered_pressure_pa,
                status, output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bpc_div.sv
`default_nettype none
module bpc_div import bpc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic      [DIV_W-1:0] quotient_o,
  output logic                  done_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W:0]       rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_W-1:0]     dsr_q;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W+1:0]     diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dsr_q};
  assign ge     = !diff[DIV_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W:0] : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/bpc_dp.sv
`default_nettype none
module bpc_dp import bpc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bpc_cmd_t            cmd_i,
  output bpc_sts_t                 sts_o,
  bpc_cfg_if.sink                  cfg_i,
  input  wire logic [UT_W-1:0]     raw_temperature_i,
  input  wire logic [RAW_W-1:0]    raw_pressure_i,
  output logic signed [TEMP_W-1:0] temperature_tenths_o,
  output logic [PRES_W-1:0]        pressure_pa_o,
  output logic [PRES_W-1:0]        filtered_pressure_pa_o,
  output logic [STAT_W-1:0]        status_o
);

  logic [CFG_DATA_W-1:0] c0_q, c1_q;
  logic [31:0]           c2_q;
  logic [1:0]            oss_q;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  logic [UT_W-1:0]          ut_q;
  logic [UP_W-1:0]          up_q;
  logic signed [WW-1:0]     x1_q, x2_q, x3_q, sq_q, b3_q;
  logic signed [B5_W-1:0]   b5_q, b6_q;
  logic signed [T_W-1:0]    t_q;
  logic [B4_W-1:0]          b4_q;
  logic [DIV_W-1:0]         b7_q, p_q;
  logic [PRES_W-1:0]        pc_q, filt_q;
  logic                     psat_q;
  logic [N_W-1:0]           n_q;
  logic [Q0_W-1:0]          q0_q;
  logic signed [MP_W-1:0]   prod_q;

  logic signed [TEMP_W-1:0] temp_o_q;
  logic [PRES_W-1:0]        pres_o_q, filt_o_q;
  logic [STAT_W-1:0]        stat_o_q;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [WW-1:0]   den, den_mag, mcx, mc_mag, x3p, pclamp_w;
  logic                   d1_neg, tsat, pneg, pbig;
  logic [DIV_W-1:0]       div_dvd, div_dsr, div_q;
  logic                   div_done;
  logic [DIV_W-1:0]       upb3;
  logic [23:0]            ps;
  logic [PRES_W-1:0]      pclamp;
  logic [Q0_W+3:0]        q0x10;
  logic [B4_W-1:0]        b7k;

  assign ac1 = $signed(c0_q[63:48]);
  assign ac2 = $signed(c0_q[47:32]);
  assign ac3 = $signed(c0_q[31:16]);
  assign ac4 = c0_q[15:0];
  assign ac5 = c1_q[63:48];
  assign ac6 = c1_q[47:32];
  assign b1  = $signed(c1_q[31:16]);
  assign b2  = $signed(c1_q[15:0]);
  assign mc  = $signed(c2_q[31:16]);
  assign md  = $signed(c2_q[15:0]);

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q  <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
      oss_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_AC1_AC4: c0_q  <= cfg_i.data;
        CFG_AC5_B2:  c1_q  <= cfg_i.data;
        CFG_MC_MD:   c2_q  <= cfg_i.data[31:0];
        CFG_OSS:     oss_q <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // divider operands
  assign den     = x1_q + WW'(md);
  assign den_mag = den[WW-1] ? -den : den;
  assign mcx     = WW'(mc) <<< 11;
  assign mc_mag  = mc[15] ? -mcx : mcx;
  assign d1_neg  = mc[15] ^ den[WW-1];
  assign div_dvd = (cmd_i.step == ST_T_CHK) ? mc_mag[DIV_W-1:0] :
                   (b7_q[DIV_W-1] ? b7_q : {b7_q[DIV_W-2:0], 1'b0});
  assign div_dsr = (cmd_i.step == ST_T_CHK) ? den_mag[DIV_W-1:0] :
                   {{(DIV_W-B4_W){1'b0}}, b4_q};

  bpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  assign sts_o.tzero    = (den == '0);
  assign sts_o.pzero    = (b4_q == '0);
  assign sts_o.div_done = div_done;

  // multiplier operand selection
  assign x3p  = x3_q + B4_BIAS;
  assign upb3 = DIV_W'(WW'(up_q) - b3_q);
  assign ps   = p_q[31:8];
  assign b7k  = B7_SCALE >> oss_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      ST_T_MUL: begin
        mul_a = MA_W'($signed({2'b0, ut_q}) - $signed({2'b0, ac6}));
        mul_b = MB_W'($signed({1'b0, ac5}));
      end
      ST_SQ_LO: begin
        mul_a = MA_W'(b6_q);
        mul_b = MB_W'($signed({1'b0, b6_q[13:0]}));
      end
      ST_SQ_HI: begin
        mul_a = MA_W'(b6_q);
        mul_b = MB_W'(b6_q >>> 14);
      end
      ST_SQ: begin
        mul_a = MA_W'(b6_q);
        mul_b = MB_W'(ac2);
      end
      ST_AC2: begin
        mul_a = MA_W'(sq_q);
        mul_b = MB_W'(b2);
      end
      ST_B2: begin
        mul_a = MA_W'(b6_q);
        mul_b = MB_W'(ac3);
      end
      ST_X3A: begin
        mul_a = MA_W'(sq_q);
        mul_b = MB_W'(b1);
      end
      ST_B4_MUL: begin
        mul_a = MA_W'($signed({1'b0, x3p[31:0]}));
        mul_b = MB_W'($signed({1'b0, ac4}));
      end
      ST_P_CHK: begin
        mul_a = MA_W'($signed({1'b0, upb3}));
        mul_b = MB_W'($signed({1'b0, b7k}));
      end
      ST_PS_LO: begin
        mul_a = MA_W'($signed({1'b0, ps}));
        mul_b = MB_W'($signed({1'b0, ps[13:0]}));
      end
      ST_PS_HI: begin
        mul_a = MA_W'($signed({1'b0, ps}));
        mul_b = MB_W'($signed({1'b0, ps[23:14]}));
      end
      ST_C1: begin
        mul_a = MA_W'(x1_q);
        mul_b = C_P1;
      end
      ST_C2: begin
        mul_a = MA_W'($signed({1'b0, p_q}));
        mul_b = C_P2;
      end
      ST_F_MUL: begin
        mul_a = MA_W'($signed({1'b0, n_q}));
        mul_b = DIV10_M;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // pressure clamp, x3_q holds the corrected pressure by then
  assign pneg     = x3_q[WW-1];
  assign pbig     = x3_q > PMAX;
  assign pclamp_w = pneg ? '0 : (pbig ? PMAX : x3_q);
  assign pclamp   = pclamp_w[PRES_W-1:0];
  assign q0x10    = {q0_q, 3'b0} + {2'b0, q0_q, 1'b0};
  assign tsat     = (t_q > TEMP_MAX) || (t_q < TEMP_MIN);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ut_q <= raw_temperature_i;
      up_q <= UP_W'(raw_pressure_i >> (4'd8 - {2'b0, oss_q}));
    end
    if (cmd_i.exec) begin
      case (cmd_i.step)
        ST_T_X1:  x1_q <= WW'(prod_q >>> 15);
        ST_T_X2:  x2_q <= d1_neg ? -$signed(WW'(div_q)) : $signed(WW'(div_q));
        ST_T_B5:  b5_q <= B5_W'(x1_q + x2_q);
        ST_T_B6: begin
          t_q  <= T_W'((b5_q + B5_W'(8)) >>> 4);
          b6_q <= b5_q - TEMP_OFFS;
        end
        ST_SQ_HI: sq_q <= WW'(prod_q);
        ST_SQ:    sq_q <= (sq_q + (WW'(prod_q) <<< 14)) >>> 12;
        ST_AC2:   x2_q <= WW'(prod_q >>> 11);
        ST_B2:    x1_q <= WW'(prod_q >>> 11);
        ST_X3A: begin
          x3_q <= x1_q + x2_q;
          x2_q <= WW'(prod_q >>> 13);
        end
        ST_B3: begin
          b3_q <= ((((WW'(ac1) <<< 2) + x3_q) <<< oss_q) + WW'(2)) >>> 2;
          x1_q <= WW'(prod_q >>> 16);
        end
        ST_X3B:   x3_q <= (x1_q + x2_q + WW'(2)) >>> 2;
        ST_B4:    b4_q <= prod_q[31:15];
        ST_B7:    b7_q <= prod_q[31:0];
        ST_P_Q:   p_q  <= b7_q[DIV_W-1] ? {div_q[DIV_W-2:0], 1'b0} : div_q;
        ST_PS_HI: x1_q <= WW'(prod_q);
        ST_PS:    x1_q <= x1_q + (WW'(prod_q) <<< 14);
        ST_C2:    x1_q <= WW'(prod_q >>> 16);
        ST_C3:    x2_q <= WW'(prod_q >>> 16);
        ST_PCOR:  x3_q <= $signed({32'b0, p_q}) + ((x1_q + x2_q + C_P3) >>> 4);
        ST_SAT: begin
          pc_q   <= pclamp;
          psat_q <= pneg || pbig;
          n_q    <= N_W'(pclamp) + N_W'({filt_q, 3'b0}) + N_W'(filt_q);
        end
        ST_F_Q:   q0_q <= prod_q[DIV10_SH+Q0_W-1:DIV10_SH];
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else if (cmd_i.exec && cmd_i.step == ST_FILT) begin
      filt_q <= (N_W'(q0x10) > n_q) ? PRES_W'(q0_q - 1'b1) : PRES_W'(q0_q);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      temp_o_q <= (cmd_i.code == STAT_TZERO) ? '0 :
                  (t_q > TEMP_MAX ? TEMP_W'(TEMP_MAX) :
                   (t_q < TEMP_MIN ? TEMP_W'(TEMP_MIN) : TEMP_W'(t_q)));
      pres_o_q <= (cmd_i.code == STAT_OK) ? pc_q : '0;
      filt_o_q <= filt_q;
      case (cmd_i.code)
        STAT_TZERO: stat_o_q <= STAT_TZERO;
        STAT_PZERO: stat_o_q <= STAT_PZERO;
        default:    stat_o_q <= (tsat || psat_q) ? STAT_SAT : STAT_OK;
      endcase
    end
  end

  assign temperature_tenths_o   = temp_o_q;
  assign pressure_pa_o          = pres_o_q;
  assign filtered_pressure_pa_o = filt_o_q;
  assign status_o               = stat_o_q;

endmodule
`default_nettype wire

FILE: rtl/core/bpc_ctrl.sv
`default_nettype none
module bpc_ctrl import bpc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire bpc_sts_t sts_i,
  output bpc_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  stat_e  code_q, code_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    code_d          = code_q;
    ovalid_d        = ovalid_q && !out_ready_i;
    in_ready_o      = 1'b0;
    cmd_o.step      = step_q;
    cmd_o.exec      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.load_in   = 1'b0;
    cmd_o.load_out  = 1'b0;
    cmd_o.code      = code_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = ST_T_MUL;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.exec = 1'b1;
        step_d     = step_e'(step_q + 5'd1);
        if (step_q == ST_T_CHK) begin
          if (sts_i.tzero) begin
            code_d  = STAT_TZERO;
            state_d = S_HOLD;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else if (step_q == ST_P_CHK && sts_i.pzero) begin
          code_d  = STAT_PZERO;
          state_d = S_HOLD;
        end else if (step_q == ST_P_DIV) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (step_q == ST_FILT) begin
          code_d  = STAT_OK;
          state_d = S_HOLD;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_RUN;
        end
      end
      S_HOLD: begin
        // wait for the previous result to leave the output register
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= ST_T_MUL;
      code_q   <= STAT_OK;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      code_q   <= code_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

FILE: rtl/core/barometric_pressure_compensation.sv
// Barometer integer compensation with a low-pass filtered pressure output.
// Input channel in_i: one transfer carries a raw temperature word and three
// raw pressure bytes. Output channel out_o: one transfer per input carries
// temperature in tenths of a degree, pressure in pascals, the filtered
// pressure (the new filter state) and a status code.
// Configuration channel cfg_i: calibration words and the oversampling
// setting, index 0 to 3; other indexes are ignored. Write only while idle.
// A sequencer walks 31 datapath steps over one shared 50x18 multiplier,
// and two divisions run on a radix-2 divider. A temperature divisor error
// ends the item at its check step, before either division; a pressure
// divisor error ends it at its check step, after the first division.
// One item is in flight at a time; a new item is taken once the previous
// result sits in the output register.
// When the receiver stalls, the result holds in the output register while
// the next item is computed; that item then waits until the slot frees.
// Reset clears the calibration registers, the filter state and all control.
`default_nettype none
module barometric_pressure_compensation import bpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o,
  bpc_cfg_if.sink   cfg_i
);

  bpc_cmd_t cmd;
  bpc_sts_t sts;

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpc_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .cfg_i                  (cfg_i),
    .raw_temperature_i      (in_i.raw_temperature),
    .raw_pressure_i         (in_i.raw_pressure),
    .temperature_tenths_o   (out_o.temperature_tenths),
    .pressure_pa_o          (out_o.pressure_pa),
    .filtered_pressure_pa_o (out_o.filtered_pressure_pa),
    .status_o               (out_o.status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_tzero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STAT_TZERO |->
      out_o.temperature_tenths == '0 && out_o.pressure_pa == '0)
    else $error("temperature divisor error with nonzero fields");

  a_pzero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STAT_PZERO |-> out_o.pressure_pa == '0)
    else $error("pressure divisor error with nonzero pressure");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_barometric_pressure_compensation.sv
`default_nettype none
module tb_barometric_pressure_compensation;
  import bpc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [PRES_W-1:0]        pres;
    logic [PRES_W-1:0]        filt;
    stat_e                    stat;
  } baro_res_t;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [UT_W-1:0]       ut;
    logic [RAW_W-1:0]      raw;
    bit                    typed;
    baro_res_t             res;
  } stim_row_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
  localparam int IDLE_CYCLES = 150;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 95;

  // typical calibration set
  localparam logic [63:0] CAL_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
  localparam logic [63:0] CAL_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
  localparam logic [31:0] CAL_C = {-16'sd8711, 16'sd2868};
  localparam baro_res_t RES_TZERO0 = '{temp: '0, pres: '0, filt: '0, stat: STAT_TZERO};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();
  bpc_cfg_if cfg_ch();

  barometric_pressure_compensation u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  logic [63:0]       cal_a, cal_b;
  logic [31:0]       cal_c;
  logic [1:0]        oss_r;
  logic [PRES_W-1:0] filt_state;
  baro_res_t         pending_res[$];
  int                errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic baro_res_t compensate(input logic [UT_W-1:0] ut_v,
                                           input logic [RAW_W-1:0] raw_v);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, b5, b6, b3, t, p, sq;
    logic [31:0] b4, b7, pu, x3u, b3u, upu;
    int unsigned o;
    bit sat;
    baro_res_t r;
    ac1 = longint'($signed(cal_a[63:48]));
    ac2 = longint'($signed(cal_a[47:32]));
    ac3 = longint'($signed(cal_a[31:16]));
    ac4 = longint'(cal_a[15:0]);
    ac5 = longint'(cal_b[63:48]);
    ac6 = longint'(cal_b[47:32]);
    b1  = longint'($signed(cal_b[31:16]));
    b2  = longint'($signed(cal_b[15:0]));
    mc  = longint'($signed(cal_c[31:16]));
    md  = longint'($signed(cal_c[15:0]));
    o   = oss_r;
    ut  = longint'(ut_v);
    up  = longint'(raw_v >> (8 - o));
    sat = 1'b0;
    r = '{temp: '0, pres: '0, filt: filt_state, stat: STAT_OK};

    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) begin
      r.stat = STAT_TZERO;
      return r;
    end
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    if (t > 32767) begin t = 32767; sat = 1'b1; end
    if (t < -32768) begin t = -32768; sat = 1'b1; end
    r.temp = t[15:0];

    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << o) + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;

    x3u = 32'(x3 + 32768);
    b4 = ac4[31:0] * x3u;
    b4 = b4 >> 15;
    if (b4 == 0) begin
      r.stat = STAT_PZERO;
      return r;
    end
    upu = up[31:0];
    b3u = b3[31:0];
    b7 = (upu - b3u) * (32'd50000 >> o);
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else pu = (b7 / b4) * 32'd2;

    p = longint'(pu);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (p > 262143) begin p = 262143; sat = 1'b1; end
    if (p < 0) begin p = 0; sat = 1'b1; end

    filt_state = PRES_W'((p + 9 * longint'(filt_state)) / 10);
    r.pres = p[PRES_W-1:0];
    r.filt = filt_state;
    r.stat = sat ? STAT_SAT : STAT_OK;
    return r;
  endfunction

  task automatic send_item(input logic [UT_W-1:0] ut, input logic [RAW_W-1:0] raw,
                           input bit typed, input baro_res_t res);
    baro_res_t pred;
    @(negedge clk_i);
    in_ch.raw_temperature = ut;
    in_ch.raw_pressure    = raw;
    in_ch.valid           = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = compensate(ut, raw);
    pending_res.push_back(typed ? res : pred);
  endtask

  task automatic gap(input int n);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    wait (pending_res.size() == 0);
    repeat (IDLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_AC1_AC4: cal_a = data;
      CFG_AC5_B2:  cal_b = data;
      CFG_MC_MD:   cal_c = data[31:0];
      CFG_OSS:     oss_r = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [63:0] data);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic stim_row_t item_row(input logic [UT_W-1:0] ut,
                                         input logic [RAW_W-1:0] raw,
                                         input bit typed, input baro_res_t res);
    stim_row_t s;
    s = '0;
    s.ut = ut;
    s.raw = raw;
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  // receiver: pick a new stall behavior whenever the low six bits of stall_cnt are zero
  int unsigned stall_mode = 0;
  int unsigned stall_cnt = 0;
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default: out_ch.ready <= stall_cnt[2];
    endcase
  end

  always @(posedge clk_i) begin
    baro_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        want = pending_res.pop_front();
        if (out_ch.temperature_tenths !== want.temp)
          report("temperature_tenths", out_ch.temperature_tenths, want.temp);
        if (out_ch.pressure_pa !== want.pres)
          report("pressure_pa", out_ch.pressure_pa, want.pres);
        if (out_ch.filtered_pressure_pa !== want.filt)
          report("filtered_pressure_pa", out_ch.filtered_pressure_pa, want.filt);
        if (out_ch.status !== want.stat)
          report("status", out_ch.status, want.stat);
      end
    end
  end

  initial begin
    #(40_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[$];
    logic [UT_W-1:0] ut;
    logic [RAW_W-1:0] raw;
    int burst;
    int items;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    cal_a = '0;
    cal_b = '0;
    cal_c = '0;
    oss_r = '0;
    filt_state = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero calibration: temperature divisor is zero
    dir_rows.push_back(item_row(16'h0000, 24'h000000, 1'b1, RES_TZERO0));
    dir_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b1, RES_TZERO0));
    dir_rows.push_back(item_row(16'h5555, 24'hAAAAAA, 1'b1, RES_TZERO0));
    dir_rows.push_back(cfg_row(CFG_AC1_AC4, CAL_A));
    dir_rows.push_back(cfg_row(CFG_AC5_B2, CAL_B));
    dir_rows.push_back(cfg_row(CFG_MC_MD, {32'hDEAD_BEEF, CAL_C}));
    dir_rows.push_back(cfg_row(CFG_OSS, 64'd0));
    dir_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b0, '0));
    dir_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b0, '0));
    dir_rows.push_back(item_row(16'h0000, 24'h000000, 1'b0, '0));
    dir_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_OSS, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(item_row(16'd27898, 24'h5D23A0, 1'b0, '0));
    dir_rows.push_back(item_row(16'hFFFF, 24'h000000, 1'b0, '0));
    // out-of-range index must leave every register alone
    dir_rows.push_back(cfg_row(CFG_UNUSED, 64'd0));
    dir_rows.push_back(item_row(16'd30000, 24'h7FFFFF, 1'b0, '0));
    // AC4 zero: pressure divisor zero
    dir_rows.push_back(cfg_row(CFG_AC1_AC4, {CAL_A[63:16], 16'd0}));
    dir_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b0, '0));
    dir_rows.push_back(item_row(16'h8000, 24'h800000, 1'b0, '0));
    // huge MC over a tiny divisor: temperature saturates
    dir_rows.push_back(cfg_row(CFG_AC1_AC4, CAL_A));
    dir_rows.push_back(cfg_row(CFG_MC_MD, {16'sd32767, 16'sd1}));
    dir_rows.push_back(item_row(16'd23153, 24'h5D2300, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_MC_MD, {-16'sd32768, 16'sd1}));
    dir_rows.push_back(item_row(16'd23153, 24'hFFFFFF, 1'b0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        gap(0);
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].ut, dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gap(0);
      wait_idle();
      kind = (ph < 2) ? ph : $urandom_range(0, 3);
      case (kind)
        0: begin
          write_reg(CFG_AC1_AC4, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_AC5_B2, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_MC_MD, 64'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_AC1_AC4, CAL_A);
          write_reg(CFG_AC5_B2, CAL_B);
          write_reg(CFG_MC_MD, CAL_C);
        end
        2: begin
          write_reg(CFG_AC1_AC4, {$urandom, $urandom});
          write_reg(CFG_AC5_B2, {$urandom, $urandom});
          write_reg(CFG_MC_MD, $urandom);
        end
        default: begin
          // typical set with random low bits
          write_reg(CFG_AC1_AC4, CAL_A ^ {4{4'h0, 12'($urandom_range(0, 255))}});
          write_reg(CFG_AC5_B2, CAL_B ^ {4{4'h0, 12'($urandom_range(0, 255))}});
          write_reg(CFG_MC_MD, CAL_C ^ {2{4'h0, 12'($urandom_range(0, 255))}});
        end
      endcase
      write_reg(CFG_OSS, 64'(ph % 4));
      items = 0;
      while (items < PHASE_ITEMS) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && items < PHASE_ITEMS; b++) begin
          if ($urandom_range(0, 1)) begin
            ut  = UT_W'($urandom_range(24000, 34000));
            raw = RAW_W'($urandom_range(24'h400000, 24'hB00000));
          end else begin
            ut  = UT_W'($urandom);
            raw = RAW_W'($urandom);
          end
          send_item(ut, raw, 1'b0, '0);
          items++;
        end
        // every few bursts run back to back
        if ($urandom_range(0, 3) != 0) gap($urandom_range(0, 150));
      end
    end

    gap(0);
    wait (pending_res.size() == 0);
    repeat (IDLE_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
